@@ hw/rtl/sitoa_pkg.sv @@
`timescale 1ns / 1ps

package sitoa_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONVERT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctrl;

    localparam logic [5:0] C_ASCII_ZERO  = 6'd48;
    localparam logic [5:0] C_ASCII_MINUS = 6'd45;
    localparam logic [3:0] C_BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] C_BCD_ADJ_ADD = 4'd3;
    localparam logic [3:0] C_BCD_MAX     = 4'd9;

endpackage

@@ hw/rtl/sitoa_bcd_cell.sv @@
`timescale 1ns / 1ps

module sitoa_bcd_cell (
    input  logic                  i_clk,
    input  sitoa_pkg::t_cell_ctrl i_ctrl,
    input  logic                  i_bit,
    output logic                  o_carry,
    output logic [3:0]            o_digit
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] w_adj;

    // The add-3 correction keeps the digit decimal after the doubling shift.
    assign w_adj = (r_digit >= sitoa_pkg::C_BCD_ADJ_MIN) ?
                   (r_digit + sitoa_pkg::C_BCD_ADJ_ADD) : r_digit;

    assign o_carry = w_adj[3];
    assign o_digit = r_digit;

    always_comb begin
        priority if (i_ctrl.clear) begin
            n_digit = 4'd0;
        end else if (i_ctrl.shift) begin
            n_digit = {w_adj[2:0], i_bit};
        end else begin
            n_digit = r_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

@@ hw/rtl/signed_int_to_decimal_ascii_unit.sv @@
`timescale 1ns / 1ps

// Signed integer to decimal ASCII converter.
// A request on the input channel (i_valid/o_ready) carries one two's complement
// value of VALUE_BITS bits. The block answers with its decimal text on the
// output channel (o_valid/i_ready), one character per transfer, most significant
// first: a minus sign for negative values, then the digits without leading
// zeros. Zero gives a single '0'. o_last_char marks the final character.
// The magnitude is fed MSB first into a row of BCD digit cells that double
// and adjust once per magnitude bit while the block converts. The characters
// then leave at one per cycle while the receiver is ready.
// o_ready is high only while no item is in work. The last character sits in
// the output register, so the next input is taken while it waits.
// A stalled receiver holds the current character and pauses the emission.
// Reset empties the output register and returns the block to idle.
module signed_int_to_decimal_ascii_unit #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [VALUE_BITS-1:0] i_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [5:0]                   o_character,
    output logic                         o_last_char
);

    localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int DIG_W      = $clog2(NUM_DIGITS + 1);
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam int CNT_W      = $clog2(VALUE_BITS);

    sitoa_pkg::t_state     r_state;
    sitoa_pkg::t_state     n_state;
    logic [VALUE_BITS-1:0] r_mag;
    logic [VALUE_BITS-1:0] n_mag;
    logic [CNT_W-1:0]      r_bit_cnt;
    logic [CNT_W-1:0]      n_bit_cnt;
    logic [DIG_W-1:0]      r_ndig;
    logic [DIG_W-1:0]      n_ndig;
    logic                  r_neg;
    logic                  n_neg;
    logic                  r_sign_pend;
    logic                  n_sign_pend;
    logic [IDX_W-1:0]      r_emit_idx;
    logic [IDX_W-1:0]      n_emit_idx;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [5:0]            r_out_char;
    logic [5:0]            n_out_char;
    logic                  r_out_last;
    logic                  n_out_last;

    logic                  w_accept;
    logic                  w_out_free;
    logic [VALUE_BITS-1:0] w_raw;
    logic [VALUE_BITS-1:0] w_abs;
    logic                  w_grow;
    logic [3:0]            w_digit;
    sitoa_pkg::t_cell_ctrl w_cell_ctrl;
    logic [NUM_DIGITS-1:0] w_cin;
    logic [3:0]            w_digits [NUM_DIGITS];

    assign w_accept   = i_valid && (r_state == sitoa_pkg::S_IDLE);
    assign w_out_free = !r_out_valid || i_ready;
    assign w_raw      = $unsigned(i_value);
    assign w_abs      = w_raw[VALUE_BITS-1] ?
                        (~w_raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : w_raw;

    assign w_cell_ctrl.clear = w_accept;
    assign w_cell_ctrl.shift = (r_state == sitoa_pkg::S_CONVERT);

    assign w_cin[0] = r_mag[VALUE_BITS-1];

    genvar g;
    generate
        for (g = 0; g < NUM_DIGITS; g++) begin : g_cell
            if (g < NUM_DIGITS - 1) begin : g_mid
                sitoa_bcd_cell u_cell (
                    .i_clk   (i_clk),
                    .i_ctrl  (w_cell_ctrl),
                    .i_bit   (w_cin[g]),
                    .o_carry (w_cin[g+1]),
                    .o_digit (w_digits[g])
                );
            end else begin : g_top
                sitoa_bcd_cell u_cell (
                    .i_clk   (i_clk),
                    .i_ctrl  (w_cell_ctrl),
                    .i_bit   (w_cin[g]),
                    .o_carry (),
                    .o_digit (w_digits[g])
                );
            end
        end
    endgenerate

    // The value at most doubles per step, so the significant digit count grows
    // by one exactly when a bit enters the cell just above the significant digits.
    assign w_grow  = (r_ndig < DIG_W'(NUM_DIGITS)) && w_cin[r_ndig[IDX_W-1:0]];
    assign w_digit = w_digits[r_emit_idx];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sitoa_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = sitoa_pkg::S_CONVERT;
                end
            end
            sitoa_pkg::S_CONVERT: begin
                if (r_bit_cnt == '0) begin
                    n_state = sitoa_pkg::S_EMIT;
                end
            end
            sitoa_pkg::S_EMIT: begin
                if (w_out_free && !r_sign_pend && (r_emit_idx == '0)) begin
                    n_state = sitoa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sitoa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_mag       = r_mag;
        n_bit_cnt   = r_bit_cnt;
        n_ndig      = r_ndig;
        n_neg       = r_neg;
        n_sign_pend = r_sign_pend;
        n_emit_idx  = r_emit_idx;
        n_out_valid = r_out_valid && !i_ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        unique case (r_state)
            sitoa_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_mag     = w_abs;
                    n_bit_cnt = CNT_W'(VALUE_BITS - 1);
                    n_ndig    = '0;
                    n_neg     = w_raw[VALUE_BITS-1];
                end
            end
            sitoa_pkg::S_CONVERT: begin
                n_mag     = {r_mag[VALUE_BITS-2:0], 1'b0};
                n_bit_cnt = r_bit_cnt - CNT_W'(1);
                n_ndig    = r_ndig + DIG_W'(w_grow);
                if (r_bit_cnt == '0) begin
                    n_sign_pend = r_neg;
                    n_emit_idx  = (n_ndig == '0) ? '0 : IDX_W'(n_ndig - DIG_W'(1));
                end
            end
            sitoa_pkg::S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_sign_pend) begin
                        n_out_char  = sitoa_pkg::C_ASCII_MINUS;
                        n_out_last  = 1'b0;
                        n_sign_pend = 1'b0;
                    end else begin
                        n_out_char = sitoa_pkg::C_ASCII_ZERO + {2'b00, w_digit};
                        n_out_last = (r_emit_idx == '0);
                        if (r_emit_idx != '0) begin
                            n_emit_idx = r_emit_idx - IDX_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sitoa_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_sign_pend <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_sign_pend <= n_sign_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag      <= n_mag;
        r_bit_cnt  <= n_bit_cnt;
        r_ndig     <= n_ndig;
        r_neg      <= n_neg;
        r_emit_idx <= n_emit_idx;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_ready     = (r_state == sitoa_pkg::S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_character = r_out_char;
    assign o_last_char = r_out_last;

    a_ndig_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sitoa_pkg::S_EMIT) |-> (r_ndig <= DIG_W'(NUM_DIGITS)))
        else $error("Significant digit count exceeds the digit row.");

    a_emit_idx_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sitoa_pkg::S_EMIT) |->
        ((DIG_W'(r_emit_idx) < r_ndig) || ((r_ndig == '0) && (r_emit_idx == '0))))
        else $error("Emit index points above the significant digits.");

    a_digit_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sitoa_pkg::S_EMIT) |-> (w_digit <= sitoa_pkg::C_BCD_MAX))
        else $error("Digit cell holds a non-decimal value.");

    a_last_on_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == sitoa_pkg::S_EMIT) && (n_state == sitoa_pkg::S_IDLE)) |=>
        (r_out_valid && r_out_last))
        else $error("Conversion ended without a final character.");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int  N_RANDOM    = 450;
    localparam int  QUIET_TAIL  = 40;
    localparam int  DRAIN_WAIT  = 60;
    localparam int  CYCLE_LIMIT = 400000;

    typedef struct {
        logic [5:0] code;
        logic       last;
    } t_char_exp;

    typedef struct {
        logic [31:0] value;
        string       text;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_value;
    logic        o_valid;
    logic        i_ready;
    logic [5:0]  o_character;
    logic        o_last_char;

    t_char_exp pending_chars[$];
    t_dir_row  dir_rows[20];
    int        error_count;
    int        cycle_count;
    bit        quiet;

    signed_int_to_decimal_ascii_unit #(
        .VALUE_BITS(32)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_character(o_character),
        .o_last_char(o_last_char)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic void queue_decimal_text(input logic [31:0] raw);
        logic [31:0] mag;
        logic [3:0]  digs[10];
        int          n;
        logic        neg;
        neg = raw[31];
        mag = neg ? (~raw + 32'd1) : raw;
        n = 0;
        if (mag == 32'd0) begin
            pending_chars.push_back('{sitoa_pkg::C_ASCII_ZERO, 1'b1});
            return;
        end
        while (mag != 32'd0) begin
            digs[n] = 4'(mag % 32'd10);
            mag = mag / 32'd10;
            n++;
        end
        if (neg) begin
            pending_chars.push_back('{sitoa_pkg::C_ASCII_MINUS, 1'b0});
        end
        for (int i = n - 1; i >= 0; i--) begin
            pending_chars.push_back('{sitoa_pkg::C_ASCII_ZERO + 6'(digs[i]), i == 0});
        end
    endfunction

    function automatic void queue_literal_text(input string s);
        byte b;
        for (int i = 0; i < s.len(); i++) begin
            b = s[i];
            pending_chars.push_back('{b[5:0], i == s.len() - 1});
        end
    endfunction

    function automatic logic [31:0] pick_random_value();
        logic [63:0] pow10;
        logic [31:0] mag;
        int          k;
        int          sel;
        sel = $urandom_range(0, 9);
        pow10 = 64'd1;
        case (sel)
            0, 1, 2, 3: begin
                return $urandom();
            end
            4, 5, 6: begin
                k = $urandom_range(1, 10);
                for (int i = 0; i < k; i++) pow10 = pow10 * 64'd10;
                if (k == 10) begin
                    mag = $urandom() >> 1;
                end else begin
                    mag = 32'($urandom() % pow10);
                end
                return ($urandom_range(0, 1) != 0) ? (~mag + 32'd1) : mag;
            end
            7: begin
                return 32'($urandom_range(0, 40)) - 32'd20;
            end
            8: begin
                if ($urandom_range(0, 1) != 0) begin
                    return 32'h7FFFFFFF - 32'($urandom_range(0, 3));
                end
                return 32'h80000000 + 32'($urandom_range(0, 3));
            end
            default: begin
                k = $urandom_range(0, 9);
                for (int i = 0; i < k; i++) pow10 = pow10 * 64'd10;
                mag = 32'(pow10) + 32'($urandom_range(0, 2)) - 32'd1;
                return ($urandom_range(0, 1) != 0) ? (~mag + 32'd1) : mag;
            end
        endcase
    endfunction

    task automatic send_request(input logic [31:0] v, input string text);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_value = v;
        do @(posedge i_clk); while (!o_ready);
        if (text.len() != 0) begin
            queue_literal_text(text);
        end else begin
            queue_decimal_text(v);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_char_exp want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected character %0d", o_character));
            end else begin
                want = pending_chars.pop_front();
                if (o_character !== want.code) begin
                    report_mismatch($sformatf("character %0d, want %0d",
                                              o_character, want.code));
                end
                if (o_last_char !== want.last) begin
                    report_mismatch($sformatf("last_char %0b, want %0b",
                                              o_last_char, want.last));
                end
            end
        end
    end

    initial begin
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                i_ready = 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(negedge i_clk);
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    initial begin
        error_count = 0;
        cycle_count = 0;
        quiet       = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_value     = 32'd0;

        dir_rows = '{
            '{32'd0,          "0"},
            '{32'd1,          "1"},
            '{32'hFFFFFFFF,   "-1"},
            '{32'd9,          ""},
            '{32'd10,         ""},
            '{-32'sd10,       ""},
            '{32'd99,         ""},
            '{32'd100,        ""},
            '{-32'sd12345,    ""},
            '{32'h7FFFFFFF,   "2147483647"},
            '{32'h80000000,   "-2147483648"},
            '{32'h80000001,   "-2147483647"},
            '{32'd1000000000, ""},
            '{32'd999999999,  ""},
            '{-32'sd1000000000, ""},
            '{32'h55555555,   ""},
            '{32'hAAAAAAAA,   ""},
            '{32'h0000FFFF,   ""},
            '{32'hFFFF0000,   ""},
            '{32'd7,          ""}
        };

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].value, dir_rows[i].text);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n >= N_RANDOM - QUIET_TAIL) quiet = 1'b1;
            send_request(pick_random_value(), "");
        end
        @(negedge i_clk);
        i_valid = 1'b0;

        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (pending_chars.size() != 0) begin
            report_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));
        end
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
